/* rtl/pn3_pkg.sv */
// Package: types, constants and helpers for the 3D noise sampler
`timescale 1ns / 1ps
package pn3_pkg;
    localparam int TABLE_SIZE = 256;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = 48;
    localparam int OFS_W      = 24;
    localparam int OUT_W      = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int VAL_W      = FRAC_BITS + 6;

    localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Z_OFFSET = 2'd2;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_EVAL  = 1'b1;

    typedef logic signed [VAL_W-1:0] val_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_FADE,
        ST_RD_A,
        ST_RD_B,
        ST_RD_AA,
        ST_RD_AB,
        ST_RD_BA,
        ST_RD_BB,
        ST_RD_G,
        ST_LERP_X,
        ST_LERP_Y,
        ST_LERP_Z,
        ST_OUT
    } state_t;

    function automatic val_t grad(input logic [3:0] h, input val_t x, input val_t y,
                                  input val_t z);
        val_t u;
        val_t v;
        u = (h < 4'd8) ? x : y;
        v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction
endpackage

/* rtl/perlin_noise_3d_sample.sv */
// Top level: 3D improved noise sampler with permutation store
//
// Usage:
//   Input channel (in_valid/in_stall): func 0 writes table_value to entry
//   table_index of the permutation store and yields no item; func 1 evaluates
//   noise at (coord_x, coord_y, coord_z) plus the offset registers.
//   Output channel (out_valid/out_stall) carries noise_value, signed Q1.16.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   x_offset, y_offset, z_offset; write only while idle.
// Timing:
//   A write item leaves the sampler idle. A sample runs in turn 12 fade
//   multiplies, 14 chained reads of the single store port, 7 lerps and a
//   saturate step; the multiplies and lerps go through one shared multiplier
//   with a registered product. The next item can be taken once the result is
//   in the output register. One sample in flight; in_stall is high while busy.
// Reset clears control and offsets; the store holds nothing until written.
// A stalled result is held in the output register; a following sample runs
// and waits in its last step until that register is free.
`timescale 1ns / 1ps
module perlin_noise_3d_sample
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               func,
    input  logic [7:0]                         table_index,
    input  logic [7:0]                         table_value,
    input  logic signed [pn3_pkg::COORD_W-1:0] coord_x,
    input  logic signed [pn3_pkg::COORD_W-1:0] coord_y,
    input  logic signed [pn3_pkg::COORD_W-1:0] coord_z,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [pn3_pkg::OUT_W-1:0]   noise_value,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pn3_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pn3_pkg::OFS_W-1:0]          cfg_data
);
    import pn3_pkg::*;

    state_t state_reg, state_next;
    logic [4:0] step_reg, step_next;
    logic [OFS_W-1:0] xo_reg, yo_reg, zo_reg;
    logic [IDX_W-1:0] xc_reg, yc_reg, zc_reg;
    val_t fx_reg, fy_reg, fz_reg;
    val_t u_reg, v_reg, w_reg;
    val_t p_reg, p_next;
    logic [IDX_W-1:0] a_reg, a_next, b_reg, b_next;
    logic [IDX_W-1:0] aa_reg, aa_next, ab_reg, ab_next;
    logic [IDX_W-1:0] ba_reg, ba_next, bb_reg, bb_next;
    val_t g_reg [8];
    val_t g_next [8];
    logic signed [OUT_W-1:0] out_reg, out_next;
    logic out_valid_reg, out_valid_next;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_addr;
    logic [7:0]           ram_rdata;
    val_t                 mul_a, mul_b, add_c, mul_res;
    logic [COORD_W-1:0]   px, py, pz;
    logic                 in_acc;
    val_t                 one_v, tsel, fsel;
    logic [IDX_W-1:0]     hsum;

    assign one_v = val_t'(1 << FRAC_BITS);
    assign in_acc = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign noise_value = out_reg;
    assign ram_we = in_acc && (func == FUNC_WRITE);

    pn3_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(table_value), .rdata(ram_rdata)
    );

    pn3_mul u_mul (.clk(clk), .mul_a(mul_a), .mul_b(mul_b), .add_c(add_c), .res(mul_res));

    assign px = coord_x + COORD_W'(xo_reg);
    assign py = coord_y + COORD_W'(yo_reg);
    assign pz = coord_z + COORD_W'(zo_reg);
    assign hsum = ram_rdata[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            xo_reg        <= '0;
            yo_reg        <= '0;
            zo_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_X_OFFSET: xo_reg <= cfg_data;
                    REG_Y_OFFSET: yo_reg <= cfg_data;
                    REG_Z_OFFSET: zo_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && func == FUNC_EVAL)
        begin
            xc_reg <= px[FRAC_BITS +: IDX_W];
            yc_reg <= py[FRAC_BITS +: IDX_W];
            zc_reg <= pz[FRAC_BITS +: IDX_W];
            fx_reg <= val_t'({1'b0, px[FRAC_BITS-1:0]});
            fy_reg <= val_t'({1'b0, py[FRAC_BITS-1:0]});
            fz_reg <= val_t'({1'b0, pz[FRAC_BITS-1:0]});
        end
        if (state_reg == ST_FADE && step_reg[2:0] == 3'd7)
        begin
            case (step_reg[4:3])
                2'd0: u_reg <= (p_next < 0) ? '0 : (p_next > one_v) ? one_v : p_next;
                2'd1: v_reg <= (p_next < 0) ? '0 : (p_next > one_v) ? one_v : p_next;
                default: w_reg <= (p_next < 0) ? '0 : (p_next > one_v) ? one_v : p_next;
            endcase
        end
        p_reg  <= p_next;
        a_reg  <= a_next;
        b_reg  <= b_next;
        aa_reg <= aa_next;
        ab_reg <= ab_next;
        ba_reg <= ba_next;
        bb_reg <= bb_next;
        g_reg  <= g_next;
        out_reg <= out_next;
    end

    // fade: 4 multiplies per axis, each an issue step and a result step
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        p_next         = p_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        aa_next        = aa_reg;
        ab_next        = ab_reg;
        ba_next        = ba_reg;
        bb_next        = bb_reg;
        g_next         = g_reg;
        ram_addr       = table_index[IDX_W-1:0];
        mul_a          = p_reg;
        mul_b          = fx_reg;
        add_c          = '0;
        tsel           = fx_reg;
        fsel           = u_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (step_reg[4:3])
            2'd1: tsel = fy_reg;
            2'd2: tsel = fz_reg;
            default: tsel = fx_reg;
        endcase
        mul_b = tsel;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && func == FUNC_EVAL)
                begin
                    state_next = ST_FADE;
                    step_next  = '0;
                end
            end
            ST_FADE:
            begin
                // step[4:3] axis, step[2:0] phase: even issue, odd capture
                if (step_reg[2:0] == 3'd0)
                begin
                    mul_a = val_t'(6 * tsel - 15 * one_v);
                    add_c = val_t'(10 * one_v);
                end
                if (step_reg[0])
                    p_next = mul_res;
                if (step_reg == 5'd23)
                begin
                    state_next = ST_RD_A;
                    step_next  = '0;
                end
                else
                    step_next = step_reg + 5'd1;
            end
            ST_RD_A:
            begin
                ram_addr = step_reg[0] ? xc_reg + IDX_W'(1) : xc_reg;
                if (step_reg == 5'd1)
                    a_next = hsum + yc_reg;
                if (step_reg == 5'd2)
                begin
                    b_next = hsum + yc_reg;
                    state_next = ST_RD_AA;
                    step_next = '0;
                end
                else
                    step_next = step_reg + 5'd1;
            end
            ST_RD_AA:
            begin
                case (step_reg[1:0])
                    2'd0: ram_addr = a_reg;
                    2'd1: ram_addr = a_reg + IDX_W'(1);
                    2'd2: ram_addr = b_reg;
                    default: ram_addr = b_reg + IDX_W'(1);
                endcase
                case (step_reg)
                    5'd1: aa_next = hsum + zc_reg;
                    5'd2: ab_next = hsum + zc_reg;
                    5'd3: ba_next = hsum + zc_reg;
                    5'd4: bb_next = hsum + zc_reg;
                    default: ;
                endcase
                if (step_reg == 5'd4)
                begin
                    state_next = ST_RD_G;
                    step_next = '0;
                end
                else
                    step_next = step_reg + 5'd1;
            end
            ST_RD_G:
            begin
                case (step_reg[2:0])
                    3'd0: ram_addr = aa_reg;
                    3'd1: ram_addr = ba_reg;
                    3'd2: ram_addr = ab_reg;
                    3'd3: ram_addr = bb_reg;
                    3'd4: ram_addr = aa_reg + IDX_W'(1);
                    3'd5: ram_addr = ba_reg + IDX_W'(1);
                    3'd6: ram_addr = ab_reg + IDX_W'(1);
                    default: ram_addr = bb_reg + IDX_W'(1);
                endcase
                if (step_reg != 5'd0)
                begin
                    case (step_reg[3:0])
                        4'd1: g_next[0] = grad(ram_rdata[3:0], fx_reg, fy_reg, fz_reg);
                        4'd2: g_next[1] = grad(ram_rdata[3:0], fx_reg - one_v, fy_reg, fz_reg);
                        4'd3: g_next[2] = grad(ram_rdata[3:0], fx_reg, fy_reg - one_v, fz_reg);
                        4'd4: g_next[3] = grad(ram_rdata[3:0], fx_reg - one_v,
                                               fy_reg - one_v, fz_reg);
                        4'd5: g_next[4] = grad(ram_rdata[3:0], fx_reg, fy_reg, fz_reg - one_v);
                        4'd6: g_next[5] = grad(ram_rdata[3:0], fx_reg - one_v, fy_reg,
                                               fz_reg - one_v);
                        4'd7: g_next[6] = grad(ram_rdata[3:0], fx_reg, fy_reg - one_v,
                                               fz_reg - one_v);
                        default: g_next[7] = grad(ram_rdata[3:0], fx_reg - one_v,
                                                  fy_reg - one_v, fz_reg - one_v);
                    endcase
                end
                if (step_reg == 5'd8)
                begin
                    state_next = ST_LERP_X;
                    step_next = '0;
                end
                else
                    step_next = step_reg + 5'd1;
            end
            ST_LERP_X, ST_LERP_Y, ST_LERP_Z:
            begin
                // step[2:1] pair, step[0]: 0 issue, 1 capture
                fsel = (state_reg == ST_LERP_X) ? u_reg :
                       (state_reg == ST_LERP_Y) ? v_reg : w_reg;
                mul_a = fsel;
                mul_b = g_reg[{step_reg[2:1], 1'b1}] - g_reg[{step_reg[2:1], 1'b0}];
                add_c = g_reg[{step_reg[2:1], 1'b0}];
                if (step_reg[0])
                    g_next[{1'b0, step_reg[2:1]}] = mul_res;
                if ((state_reg == ST_LERP_X && step_reg == 5'd7) ||
                    (state_reg == ST_LERP_Y && step_reg == 5'd3))
                begin
                    state_next = (state_reg == ST_LERP_X) ? ST_LERP_Y : ST_LERP_Z;
                    step_next = '0;
                end
                else if (state_reg == ST_LERP_Z && step_reg == 5'd1)
                    state_next = ST_OUT;
                else
                    step_next = step_reg + 5'd1;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    if (g_reg[0] > val_t'(131071))
                        out_next = OUT_W'(131071);
                    else if (g_reg[0] < -val_t'(131072))
                        out_next = OUT_W'(-131072);
                    else
                        out_next = g_reg[0][OUT_W-1:0];
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n) out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
                     out_valid && out_stall |=> $stable(noise_value))
        else $error("result changed while stalled");
    assert property (@(posedge clk) disable iff (!rst_n) state_reg != ST_IDLE |-> in_stall)
        else $error("input taken while busy");
endmodule

/* rtl/pn3_ram.sv */
// Generic single-port RAM with registered read
`timescale 1ns / 1ps
module pn3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

/* rtl/pn3_mul.sv */
// Shared rounded fixed-point multiply: add_c + round(mul_a * mul_b)
`timescale 1ns / 1ps
module pn3_mul
(
    input  logic         clk,
    input  pn3_pkg::val_t mul_a,
    input  pn3_pkg::val_t mul_b,
    input  pn3_pkg::val_t add_c,
    output pn3_pkg::val_t res
);
    import pn3_pkg::*;

    logic signed [2*VAL_W-1:0] prod_reg;
    val_t                      c_reg;
    logic signed [2*VAL_W-1:0] rnd;

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        c_reg    <= add_c;
    end

    always_comb
    begin
        rnd = (prod_reg + (2*VAL_W)'(1 << (FRAC_BITS-1))) >>> FRAC_BITS;
        res = VAL_W'(rnd) + c_reg;
    end
endmodule

/* dv/tb_perlin_noise_3d_sample.sv */
// Testbench: 3D noise sampler checked against an in-bench fixed-point predictor
`timescale 1ns / 1ps
module tb_perlin_noise_3d_sample;
    import pn3_pkg::*;

    localparam longint ONE = 64'sd1 << FRAC_BITS;

    class noise_scoreboard;
        bit [7:0]                  perm [TABLE_SIZE];
        bit [OFS_W-1:0]            ofs [3];
        logic signed [OUT_W-1:0]   pending [$];
        int                        errors;

        function longint rmul(longint a, longint b);
            return (a * b + (ONE >>> 1)) >>> FRAC_BITS;
        endfunction

        function longint fade(longint t);
            longint p;
            p = 6 * t - 15 * ONE;
            p = rmul(p, t) + 10 * ONE;
            p = rmul(p, t);
            p = rmul(p, t);
            p = rmul(p, t);
            if (p < 0) p = 0;
            if (p > ONE) p = ONE;
            return p;
        endfunction

        function longint blend(longint w, longint a, longint b);
            return a + rmul(w, b - a);
        endfunction

        function longint corner(longint hash, longint x, longint y, longint z);
            bit [3:0] h;
            longint   u;
            longint   v;
            h = hash[3:0];
            u = (h < 8) ? x : y;
            v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
            return (h[0] ? -u : u) + (h[1] ? -v : v);
        endfunction

        function longint pt(longint i);
            return perm[i & (TABLE_SIZE - 1)];
        endfunction

        function void set_offset(logic [CFG_IDX_W-1:0] idx, bit [OFS_W-1:0] val);
            if (idx == REG_X_OFFSET) ofs[0] = val;
            else if (idx == REG_Y_OFFSET) ofs[1] = val;
            else if (idx == REG_Z_OFFSET) ofs[2] = val;
        endfunction

        function void note_item(logic f, bit [7:0] idx, bit [7:0] val,
                                bit [COORD_W-1:0] cx, bit [COORD_W-1:0] cy,
                                bit [COORD_W-1:0] cz);
            longint px, py, pz, fx, fy, fz, u, v, w, xc, yc, zc;
            longint a, aa, ab, b, ba, bb, n1, n2, n3, n4, r;
            if (f == FUNC_WRITE)
            begin
                perm[idx] = val;
                return;
            end
            px = longint'($signed(cx)) + ofs[0];
            py = longint'($signed(cy)) + ofs[1];
            pz = longint'($signed(cz)) + ofs[2];
            xc = (px >>> FRAC_BITS) & (TABLE_SIZE - 1);
            yc = (py >>> FRAC_BITS) & (TABLE_SIZE - 1);
            zc = (pz >>> FRAC_BITS) & (TABLE_SIZE - 1);
            fx = px & (ONE - 1);
            fy = py & (ONE - 1);
            fz = pz & (ONE - 1);
            u = fade(fx);
            v = fade(fy);
            w = fade(fz);
            a  = pt(xc) + yc;
            aa = pt(a) + zc;
            ab = pt(a + 1) + zc;
            b  = pt(xc + 1) + yc;
            ba = pt(b) + zc;
            bb = pt(b + 1) + zc;
            n1 = blend(u, corner(pt(aa), fx, fy, fz), corner(pt(ba), fx - ONE, fy, fz));
            n2 = blend(u, corner(pt(ab), fx, fy - ONE, fz),
                       corner(pt(bb), fx - ONE, fy - ONE, fz));
            n3 = blend(u, corner(pt(aa + 1), fx, fy, fz - ONE),
                       corner(pt(ba + 1), fx - ONE, fy, fz - ONE));
            n4 = blend(u, corner(pt(ab + 1), fx, fy - ONE, fz - ONE),
                       corner(pt(bb + 1), fx - ONE, fy - ONE, fz - ONE));
            r = blend(w, blend(v, n1, n2), blend(v, n3, n4));
            if (r > 131071) r = 131071;
            if (r < -131072) r = -131072;
            pending.push_back(r[OUT_W-1:0]);
        endfunction

        function void check_noise(logic signed [OUT_W-1:0] got);
            logic signed [OUT_W-1:0] want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected item: noise_value %0d", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("noise_value mismatch: expected %0d, got %0d", want, got);
            end
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic                      func = 1'b0;
    logic [7:0]                table_index = '0;
    logic [7:0]                table_value = '0;
    logic signed [COORD_W-1:0] coord_x = '0;
    logic signed [COORD_W-1:0] coord_y = '0;
    logic signed [COORD_W-1:0] coord_z = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [OUT_W-1:0]   noise_value;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [OFS_W-1:0]          cfg_data = '0;

    noise_scoreboard sb = new();
    bit              quiet = 1'b0;
    int              stall_left = 0;

    perlin_noise_3d_sample u_top (.*);

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_noise(noise_value);
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 2);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic send(logic f, bit [7:0] idx, bit [7:0] val,
                        bit [COORD_W-1:0] cx, bit [COORD_W-1:0] cy, bit [COORD_W-1:0] cz);
        func        <= f;
        table_index <= idx;
        table_value <= val;
        coord_x     <= cx;
        coord_y     <= cy;
        coord_z     <= cz;
        in_valid    <= 1'b1;
        do @(posedge clk); while (in_stall);
        sb.note_item(f, idx, val, cx, cy, cz);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic drain();
        int guard;
        in_valid <= 1'b0;
        guard = 0;
        while (sb.pending.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (60) @(posedge clk);
    endtask

    task automatic write_offsets(bit [OFS_W-1:0] x, bit [OFS_W-1:0] y, bit [OFS_W-1:0] z);
        bit [OFS_W-1:0] vals [3];
        vals = '{x, y, z};
        for (int i = 0; i < 3; i++)
        begin
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            cfg_valid <= 1'b1;
            do @(posedge clk); while (!cfg_ready);
            sb.set_offset(CFG_IDX_W'(i), vals[i]);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic bit [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return COORD_W'({$urandom, $urandom});
            1: return COORD_W'($signed($urandom_range(0, 32'h3FFFFF)) - 32'sh200000);
            2: return {{($urandom_range(0, 1) ? 16'hFFFF : 16'h0)}, $urandom};
            default: return COORD_W'($urandom_range(0, 32'hFFFFFF));
        endcase
    endfunction

    initial
    begin
        bit [7:0]         order [TABLE_SIZE];
        bit [COORD_W-1:0] edges [6];
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_offsets('0, '0, '0);
        foreach (order[i]) order[i] = 8'(i);
        order.shuffle();
        send(FUNC_WRITE, 8'd0, 8'd255, '0, '0, '0);
        send(FUNC_WRITE, 8'd255, 8'd0, '0, '0, '0);
        for (int i = 1; i < TABLE_SIZE - 1; i++)
            send(FUNC_WRITE, 8'(i), order[i], '0, '0, '0);

        edges = '{48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'h0,
                  48'hFFFF_FFFF_FFFF, 48'h0000_0000_FFFF, 48'h0000_0000_8000};
        for (int i = 0; i < 6; i++)
            send(FUNC_EVAL, 8'hFF, 8'hFF, edges[i], edges[(i + 2) % 6], edges[(i + 4) % 6]);
        send(FUNC_EVAL, 8'd0, 8'd0, edges[0], edges[0], edges[0]);
        send(FUNC_EVAL, 8'd0, 8'd0, edges[1], edges[1], edges[1]);

        for (int phase = 0; phase < 4; phase++)
        begin
            drain();
            case (phase)
                0: write_offsets(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
                1: write_offsets(OFS_W'($urandom), OFS_W'($urandom), OFS_W'($urandom));
                2: write_offsets(24'h000000, 24'hFFFFFF, 24'h00FFFF);
                default: write_offsets(OFS_W'($urandom), 24'h0, OFS_W'($urandom));
            endcase
            send(FUNC_EVAL, 8'd0, 8'd0, '0, '0, '0);
            for (int n = 0; n < 120; n++)
            begin
                if (phase == 3 && n == 80) quiet = 1'b1;
                if (phase == 1 && n == 60) drain();
                if ($urandom_range(0, 9) == 0)
                    send(FUNC_WRITE, 8'($urandom), 8'($urandom), rand_coord(), rand_coord(),
                         rand_coord());
                else
                    send(FUNC_EVAL, 8'($urandom), 8'($urandom), rand_coord(), rand_coord(),
                         rand_coord());
            end
        end
        drain();
        if (sb.pending.size() != 0) sb.errors++;
        if (sb.errors == 0)
            $display("tb_perlin_noise_3d_sample: done, clean");
        else
            $display("tb_perlin_noise_3d_sample: done, errors");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb_perlin_noise_3d_sample: done, errors");
        $finish;
    end
endmodule
